// ===== sv/smm_pkg.sv =====
// Stable matching engine package: item and result types, item kind codes,
// sequencer states. No dependencies.
package smm_pkg;

	localparam logic [1:0] KIND_DEPT = 2'd0;  // load department choice
	localparam logic [1:0] KIND_PROG = 2'd1;  // load programmer ranking entry
	localparam logic [1:0] KIND_RUN  = 2'd2;  // run matching

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] agent;
		logic [2:0] rank;
		logic [2:0] choice;
	} item_t;

	typedef struct packed {
		logic [2:0] department;
		logic [2:0] programmer;
		logic       matched;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_CHOICE,
		ST_RANK_D,
		ST_RANK_C,
		ST_EMIT
	} state_t;

endpackage

// ===== sv/smm_in_if.sv =====
// Input item channel: valid/ready handshake with item payload.
// No dependencies.
interface smm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] agent;
	logic [2:0] rank;
	logic [2:0] choice;

	modport source (output valid, kind, agent, rank, choice, input ready);
	modport sink (input valid, kind, agent, rank, choice, output ready);
endinterface

// ===== sv/smm_out_if.sv =====
// Result channel: valid/ready handshake with result payload.
// No dependencies.
interface smm_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] department;
	logic [2:0] programmer;
	logic       matched;
	logic       last;

	modport source (output valid, department, programmer, matched, last, input ready);
	modport sink (input valid, department, programmer, matched, last, output ready);
endinterface

// ===== sv/smm_core.sv =====
// Matching core: preference tables, per-agent match state and the proposal sequencer.
// Depends on smm_pkg.
module smm_core #(
	parameter int AGENTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  smm_pkg::item_t   item,
	output logic             busy,
	output logic             res_valid,
	output smm_pkg::result_t res,
	input  logic             res_ready
);

	localparam int IW    = $clog2(AGENTS);
	localparam int CW    = IW + 1;
	localparam int DEPTH = AGENTS * AGENTS;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] mem_addr(input logic [IW-1:0] row,
			input logic [IW-1:0] col);
		return AW'(int'(row) * AGENTS + int'(col));
	endfunction

	// preference tables
	logic [IW-1:0] choice_mem [DEPTH];
	logic [IW-1:0] rank_mem   [DEPTH];
	logic [IW-1:0] choice_rd_q;
	logic [IW-1:0] rank_rd_q;
	logic [AW-1:0] choice_raddr;
	logic [AW-1:0] rank_raddr;

	// match state
	logic [CW-1:0]     np_q [AGENTS];
	logic [IW-1:0]     holder_q [AGENTS];
	logic [AGENTS-1:0] holder_vld_q;
	logic [IW-1:0]     asg_q [AGENTS];
	logic [AGENTS-1:0] asg_vld_q;

	logic [IW-1:0] d_q;
	logic [IW-1:0] p_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] rank_d_q;
	logic [IW-1:0] e_q;

	smm_pkg::state_t state_q;
	smm_pkg::state_t state_d;

	logic          in_range;
	logic          load_dept;
	logic          load_prog;
	logic          run_start;
	logic          found;
	logic [IW-1:0] find_d;
	logic [CW-1:0] np_sel;
	logic [IW-1:0] p_c;
	logic          better;
	logic          emit_done;

	assign in_range = ({2'b00, item.agent} < 5'(AGENTS))
		&& ({2'b00, item.rank} < 5'(AGENTS))
		&& ({2'b00, item.choice} < 5'(AGENTS));
	assign load_dept = item_valid && (item.kind == smm_pkg::KIND_DEPT) && in_range;
	assign load_prog = item_valid && (item.kind == smm_pkg::KIND_PROG) && in_range;
	assign run_start = item_valid && (item.kind == smm_pkg::KIND_RUN);

	// lowest free department that still has list entries
	always_comb begin
		found  = 1'b0;
		find_d = '0;
		for (int i = AGENTS - 1; i >= 0; i--) begin
			if (!asg_vld_q[i] && (np_q[i] < CW'(AGENTS))) begin
				found  = 1'b1;
				find_d = IW'(i);
			end
		end
	end

	assign np_sel       = np_q[find_d];
	assign choice_raddr = mem_addr(find_d, np_sel[IW-1:0]);
	assign p_c          = choice_rd_q;
	assign better       = rank_d_q < rank_rd_q;  // tie keeps holder
	assign emit_done    = res_ready && (e_q == IW'(AGENTS - 1));

	// table memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (load_dept) begin
			choice_mem[mem_addr(IW'(item.agent), IW'(item.rank))] <= IW'(item.choice);
		end
		if (load_prog) begin
			rank_mem[mem_addr(IW'(item.agent), IW'(item.choice))] <= IW'(item.rank);
		end
		choice_rd_q <= choice_mem[choice_raddr];
		rank_rd_q   <= rank_mem[rank_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smm_pkg::ST_IDLE: begin
				if (run_start) state_d = smm_pkg::ST_FIND;
			end
			smm_pkg::ST_FIND: begin
				state_d = found ? smm_pkg::ST_CHOICE : smm_pkg::ST_EMIT;
			end
			smm_pkg::ST_CHOICE: begin
				state_d = holder_vld_q[p_c] ? smm_pkg::ST_RANK_D : smm_pkg::ST_FIND;
			end
			smm_pkg::ST_RANK_D: state_d = smm_pkg::ST_RANK_C;
			smm_pkg::ST_RANK_C: state_d = smm_pkg::ST_FIND;
			smm_pkg::ST_EMIT: begin
				if (emit_done) state_d = smm_pkg::ST_IDLE;
			end
			default: state_d = smm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy           = 1'b1;
		res_valid      = 1'b0;
		rank_raddr     = mem_addr(p_q, cur_q);
		res.department = 3'(e_q);
		res.programmer = asg_vld_q[e_q] ? 3'(asg_q[e_q]) : 3'd0;
		res.matched    = asg_vld_q[e_q];
		res.last       = (e_q == IW'(AGENTS - 1));
		unique case (state_q)
			smm_pkg::ST_IDLE:   busy = 1'b0;
			smm_pkg::ST_CHOICE: rank_raddr = mem_addr(p_c, d_q);
			smm_pkg::ST_EMIT:   res_valid = 1'b1;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= smm_pkg::ST_IDLE;
			holder_vld_q <= '0;
			asg_vld_q    <= '0;
			e_q          <= '0;
			for (int i = 0; i < AGENTS; i++) np_q[i] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				smm_pkg::ST_IDLE: begin
					if (run_start) begin
						holder_vld_q <= '0;
						asg_vld_q    <= '0;
						e_q          <= '0;
						for (int i = 0; i < AGENTS; i++) np_q[i] <= '0;
					end
				end
				smm_pkg::ST_FIND: begin
					if (found) np_q[find_d] <= np_sel + 1'b1;
				end
				smm_pkg::ST_CHOICE: begin
					if (!holder_vld_q[p_c]) begin
						holder_vld_q[p_c] <= 1'b1;
						asg_vld_q[d_q]    <= 1'b1;
					end
				end
				smm_pkg::ST_RANK_C: begin
					if (better) begin
						asg_vld_q[cur_q] <= 1'b0;
						asg_vld_q[d_q]   <= 1'b1;
					end
				end
				smm_pkg::ST_EMIT: begin
					if (res_ready) e_q <= e_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// match payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			smm_pkg::ST_FIND: d_q <= find_d;
			smm_pkg::ST_CHOICE: begin
				p_q   <= p_c;
				cur_q <= holder_q[p_c];
				if (!holder_vld_q[p_c]) begin
					holder_q[p_c] <= d_q;
					asg_q[d_q]    <= p_c;
				end
			end
			smm_pkg::ST_RANK_D: rank_d_q <= rank_rd_q;
			smm_pkg::ST_RANK_C: begin
				if (better) begin
					holder_q[p_q] <= d_q;
					asg_q[d_q]    <= p_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/stable_matching_engine.sv =====
// A load item is written in its transfer cycle. A run makes proposals: one to a free programmer
// goes through search and table read, one to a held one through search, table read, two rank
// reads and compare; at most AGENTS*AGENTS proposals, then one closing search and AGENTS
// results at full rate while the output register takes them. No items are taken during a run;
// the two table read ports and the rank compare set the pace. Reset: matching flags and the
// sequencer clear at once; preference tables hold garbage until loaded.
module stable_matching_engine #(
	parameter int AGENTS = 8
) (
	input logic      clk,
	input logic      arst_n,
	smm_in_if.sink   items,
	smm_out_if.source results
);

	smm_pkg::item_t   item;
	smm_pkg::result_t res;
	smm_pkg::result_t out_q;
	logic             out_vld_q;
	logic             busy;
	logic             res_valid;
	logic             res_ready;
	logic             item_xfer;

	// Input side: the core takes items only while its sequencer is idle.
	// Loads retire in the transfer cycle, so they stream one per cycle.
	assign items.ready = !busy;
	assign item_xfer   = items.valid && items.ready;
	assign item.kind   = items.kind;
	assign item.agent  = items.agent;
	assign item.rank   = items.rank;
	assign item.choice = items.choice;

	smm_core #(
		.AGENTS (AGENTS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_xfer),
		.item       (item),
		.busy       (busy),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready)
	);

	// Output register: parts the result stream from the core. After the last
	// result moves here the core returns to idle and can take new items while
	// that result still waits for its transfer.
	assign res_ready = !out_vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign results.valid      = out_vld_q;
	assign results.department = out_q.department;
	assign results.programmer = out_q.programmer;
	assign results.matched    = out_q.matched;
	assign results.last       = out_q.last;

endmodule

// ===== sim/match_checker.sv =====
`timescale 1ns / 100ps
// Checker for the stable matching engine: watches both channels, keeps its own
// preference tables, solves each run and compares results.
// Depends on smm_pkg, smm_in_if, smm_out_if.
module match_checker #(
	parameter int AGENTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	smm_in_if    items,
	smm_out_if   results,
	output int   errors,
	output int   pending
);

	logic [2:0]       dept_picks [AGENTS][AGENTS];  // [dept][rank] -> programmer
	logic [2:0]       prog_ranks [AGENTS][AGENTS];  // [programmer][dept] -> rank
	smm_pkg::result_t expected_matches [$];
	smm_pkg::result_t got;
	smm_pkg::result_t want;

	initial errors = 0;
	initial pending = 0;

	task automatic flag_mismatch(input string what, input int seen, input int wanted);
		$display("match_checker: %s: got %0d, expected %0d at %0t", what, seen, wanted, $time);
		errors++;
	endtask

	// Department-proposing deferred acceptance; lowest free department goes first,
	// ties keep the current holder.
	task automatic solve_matching();
		int               next_pos [AGENTS];
		bit               held [AGENTS];
		int               held_by [AGENTS];
		bit               paired [AGENTS];
		int               partner [AGENTS];
		int               d;
		int               p;
		int               cur;
		smm_pkg::result_t r;
		for (int i = 0; i < AGENTS; i++) begin
			next_pos[i] = 0;
			held[i] = 1'b0;
			held_by[i] = 0;
			paired[i] = 1'b0;
			partner[i] = 0;
		end
		forever begin
			d = AGENTS;
			for (int i = AGENTS - 1; i >= 0; i--)
				if (!paired[i] && next_pos[i] < AGENTS)
					d = i;
			if (d == AGENTS)
				break;
			p = dept_picks[d][next_pos[d]];
			next_pos[d]++;
			if (!held[p]) begin
				held[p] = 1'b1;
				held_by[p] = d;
				paired[d] = 1'b1;
				partner[d] = p;
			end else begin
				cur = held_by[p];
				if (prog_ranks[p][d] < prog_ranks[p][cur]) begin
					paired[cur] = 1'b0;
					partner[cur] = 0;
					held_by[p] = d;
					paired[d] = 1'b1;
					partner[d] = p;
				end
			end
		end
		for (int i = 0; i < AGENTS; i++) begin
			r.department = 3'(i);
			r.programmer = paired[i] ? 3'(partner[i]) : 3'd0;
			r.matched    = paired[i];
			r.last       = (i == AGENTS - 1);
			expected_matches.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AGENTS; i++)
				for (int j = 0; j < AGENTS; j++) begin
					dept_picks[i][j] = 3'd0;
					prog_ranks[i][j] = 3'd0;
				end
			expected_matches.delete();
			pending = 0;
		end else begin
			if (results.valid && results.ready) begin
				got.department = results.department;
				got.programmer = results.programmer;
				got.matched    = results.matched;
				got.last       = results.last;
				if (expected_matches.size() == 0) begin
					flag_mismatch("result with nothing expected, department", got.department, 0);
				end else begin
					want = expected_matches.pop_front();
					if (got.department !== want.department)
						flag_mismatch("department", got.department, want.department);
					if (got.programmer !== want.programmer)
						flag_mismatch("programmer", got.programmer, want.programmer);
					if (got.matched !== want.matched)
						flag_mismatch("matched", got.matched, want.matched);
					if (got.last !== want.last)
						flag_mismatch("last", got.last, want.last);
				end
			end
			if (items.valid && items.ready) begin
				unique case (items.kind)
				smm_pkg::KIND_DEPT: begin
					if (items.agent < AGENTS && items.rank < AGENTS && items.choice < AGENTS)
						dept_picks[items.agent][items.rank] = items.choice;
				end
				smm_pkg::KIND_PROG: begin
					if (items.agent < AGENTS && items.rank < AGENTS && items.choice < AGENTS)
						prog_ranks[items.agent][items.choice] = items.rank;
				end
				smm_pkg::KIND_RUN: begin
					solve_matching();
				end
				default: ;
				endcase
			end
			pending = expected_matches.size();
		end
	end

endmodule

// ===== sim/tb_stable_matching_engine.sv =====
`timescale 1ns / 100ps
// Top of the stable matching engine testbench: clock, reset, item stimulus,
// result back-pressure, watchdog and verdict. Depends on smm_pkg, the channel interfaces,
// match_checker and stable_matching_engine.
module tb_stable_matching_engine;

	localparam int         AGENTS     = 8;
	localparam logic [1:0] KIND_NOISE = 2'd3;  // unused kind, engine must drop it
	// Longest quiet stretch of a correct run: 64 contested proposals with their rank reads,
	// 8 emits, plus a long sink stall and a long source gap. Taken about ten times over.
	localparam int         QUIET_LIMIT = 4000;

	logic clk;
	logic arst_n;
	int   err_count;
	int   pend_count;
	int   quiet_cycles;
	bit   calm;  // when set, neither side inserts gaps

	smm_in_if  item_ch ();
	smm_out_if result_ch ();

	stable_matching_engine #(.AGENTS(AGENTS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch)
	);

	match_checker #(.AGENTS(AGENTS)) chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.errors  (err_count),
		.pending (pend_count)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// One item per call; valid stays up across back-to-back transfers.
	task automatic send_item(input logic [1:0] kind, input logic [2:0] agent,
			input logic [2:0] rank, input logic [2:0] choice);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.kind   <= kind;
		item_ch.agent  <= agent;
		item_ch.rank   <= rank;
		item_ch.choice <= choice;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	task automatic shuffle(output int perm [AGENTS]);
		int j;
		int t;
		for (int i = 0; i < AGENTS; i++)
			perm[i] = i;
		for (int i = AGENTS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
	endtask

	// Whole preference list of one department; repeats allowed so lists can run dry.
	task automatic load_dept_list(input int d, input bit repeats);
		int perm [AGENTS];
		shuffle(perm);
		for (int r = 0; r < AGENTS; r++)
			send_item(smm_pkg::KIND_DEPT, 3'(d), 3'(r),
				repeats ? 3'($urandom_range(0, AGENTS - 1)) : 3'(perm[r]));
	endtask

	// Whole ranking of one programmer; with ties, several departments share a rank.
	task automatic load_prog_ranking(input int p, input bit ties);
		int perm [AGENTS];
		shuffle(perm);
		for (int d = 0; d < AGENTS; d++)
			send_item(smm_pkg::KIND_PROG, 3'(p),
				ties ? 3'($urandom_range(0, AGENTS - 1)) : 3'(perm[d]), 3'(d));
	endtask

	// Sink: bursts of ready with random stalls between them.
	initial begin
		int burst;
		int gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			burst = $urandom_range(1, 12);
			result_ch.ready <= 1'b1;
			repeat (burst) @(negedge clk);
			gap = idle_len();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	// Watchdog: any transfer on either channel resets the quiet count.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_stable_matching_engine: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int rand_items;
		int runs;
		int sel;
		item_ch.valid  = 1'b0;
		item_ch.kind   = smm_pkg::KIND_DEPT;
		item_ch.agent  = 3'd0;
		item_ch.rank   = 3'd0;
		item_ch.choice = 3'd0;
		quiet_cycles   = 0;
		calm           = 1'b0;
		rand_items     = 0;
		runs           = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every table entry gets written first, so no run ever reads an unloaded entry.
		for (int i = 0; i < AGENTS; i++) begin
			load_dept_list(i, 1'b0);
			load_prog_ranking(i, 1'b0);
		end

		// Directed: plain run, dropped kind, repeated run on unchanged tables.
		send_item(smm_pkg::KIND_RUN, 3'd0, 3'd0, 3'd0);
		send_item(KIND_NOISE, 3'd7, 3'd7, 3'd7);
		send_item(smm_pkg::KIND_RUN, 3'd7, 3'd7, 3'd7);
		// Department 7 lists only programmer 0, which prefers departments 5 and 6:
		// department 7 runs out of choices. Departments 5 and 6 tie at the top of
		// programmer 0; 5 proposes first and keeps it.
		for (int r = 0; r < AGENTS; r++)
			send_item(smm_pkg::KIND_DEPT, 3'd7, 3'(r), 3'd0);
		send_item(smm_pkg::KIND_DEPT, 3'd6, 3'd0, 3'd0);
		send_item(smm_pkg::KIND_DEPT, 3'd5, 3'd0, 3'd0);
		send_item(smm_pkg::KIND_PROG, 3'd0, 3'd7, 3'd7);
		send_item(smm_pkg::KIND_PROG, 3'd0, 3'd0, 3'd6);
		send_item(smm_pkg::KIND_PROG, 3'd0, 3'd0, 3'd5);
		send_item(smm_pkg::KIND_PROG, 3'd7, 3'd7, 3'd7);
		send_item(smm_pkg::KIND_RUN, 3'd0, 3'd0, 3'd0);

		// Random: mostly whole-list reloads followed by runs, some single-entry
		// pokes and dropped kinds as noise.
		while (rand_items < 16 || runs < 3) begin
			calm = ($urandom_range(0, 5) == 0);
			sel  = $urandom_range(0, 99);
			if (sel < 25) begin
				load_dept_list($urandom_range(0, AGENTS - 1), $urandom_range(0, 9) < 3);
				rand_items += AGENTS;
			end else if (sel < 50) begin
				load_prog_ranking($urandom_range(0, AGENTS - 1), $urandom_range(0, 9) < 3);
				rand_items += AGENTS;
			end else if (sel < 72) begin
				send_item($urandom_range(0, 1) ? smm_pkg::KIND_PROG : smm_pkg::KIND_DEPT,
					3'($urandom), 3'($urandom), 3'($urandom));
				rand_items++;
			end else if (sel < 77) begin
				send_item(KIND_NOISE, 3'($urandom), 3'($urandom), 3'($urandom));
			end else begin
				send_item(smm_pkg::KIND_RUN, 3'($urandom), 3'($urandom), 3'($urandom));
				rand_items++;
				runs++;
			end
		end
		@(negedge clk);
		item_ch.valid <= 1'b0;

		// Drain, then a short settle for anything unexpected.
		while (pend_count != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb_stable_matching_engine: done, clean");
		else
			$display("tb_stable_matching_engine: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/smm_pkg.sv
sv/smm_in_if.sv
sv/smm_out_if.sv
sv/smm_core.sv
sv/stable_matching_engine.sv
sim/match_checker.sv
sim/tb_stable_matching_engine.sv
